FILE: rtl/jmsw_pkg.sv
// types, constants and the marker classifier shared by the marker segment walker
// no dependencies
package jmsw_pkg;

   localparam int POS_WIDTH = 24;
   localparam int END_WIDTH = POS_WIDTH + 1;
   localparam int OUT_WIDTH = 24;

   localparam logic [7:0] PREFIX_BYTE = 8'hff;
   localparam logic [7:0] ID_SOI      = 8'hd8;
   localparam logic [7:0] ID_APP0     = 8'he0;
   localparam logic [7:0] ID_APP2     = 8'he2;
   localparam logic [7:0] ID_DQT      = 8'hdb;
   localparam logic [7:0] ID_SOF      = 8'hc0;
   localparam logic [7:0] ID_DHT      = 8'hc4;
   localparam logic [7:0] ID_SOS      = 8'hda;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_ID,
      PH_LENHI,
      PH_LENLO,
      PH_SKIP,
      PH_SCAN,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY,
      ST_HEADER,
      ST_NOT_MARKER,
      ST_TRUNCATED,
      ST_BAD_LENGTH,
      ST_IGNORED
   } status_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_SOI,
      K_APP,
      K_DQT,
      K_SOF,
      K_DHT,
      K_SOS,
      K_UNK
   } kind_type;

   typedef struct packed {
      status_type             status;
      kind_type               marker_kind;
      logic [OUT_WIDTH-1:0]   marker_offset;
      logic [OUT_WIDTH-1:0]   scan_offset;
   } result_type;

   function automatic kind_type classify(input logic [7:0] id);
      kind_type k;
      case (id)
         ID_SOI:           k = K_SOI;
         ID_APP0, ID_APP2: k = K_APP;
         ID_DQT:           k = K_DQT;
         ID_SOF:           k = K_SOF;
         ID_DHT:           k = K_DHT;
         ID_SOS:           k = K_SOS;
         default:          k = K_UNK;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/jpeg_marker_segment_walker.sv
// top level of the jpeg marker segment walker: byte stream in, one status word out per byte
// depends on jmsw_pkg, jmsw_core, jmsw_obuf
//
// usage
//   req channel: one file byte per word on req_tdata, req_tlast on the final byte
//   of a buffer. after that byte the walker rearms for a new file.
//   rsp channel: exactly one word per input byte, in order. rsp_tuser carries the
//   status and the kind of the latest marker, rsp_tdata the offset of that
//   marker's 0xff and, with the header-done status, the offset of the first
//   scan data byte.
//   output: each word is registered in the result register before it appears on rsp.
//   throughput: one byte per cycle while req_tready is high, set by the single
//   update of the walker state register per byte.
//   stall: a result register plus one skid entry; req_tready drops only when
//   both hold words, so one more byte is taken while a word waits.
//   reset: synchronous, clears the walker state and both output entries;
//   req_tready is low while reset is high.
module jpeg_marker_segment_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] marker_offset, [47:24] scan_offset
   output logic [5:0]  rsp_tuser    // [2:0] status, [5:3] marker_kind
);
   import jmsw_pkg::*;

   logic       accept;
   logic       full;
   result_type result;
   result_type rsp_word;

   assign req_tready = !full && !reset;
   assign accept     = req_tvalid && req_tready;

   jmsw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   jmsw_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_word)
   );

   assign rsp_tdata = {rsp_word.scan_offset, rsp_word.marker_offset};
   assign rsp_tuser = {rsp_word.marker_kind, rsp_word.status};

endmodule

FILE: rtl/jmsw_core.sv
// walker state registers and the per-byte next-state and result logic
// depends on jmsw_pkg
module jmsw_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output jmsw_pkg::result_type result
);
   import jmsw_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [END_WIDTH-1:0]   seg_end_ff, seg_end_in;
   logic [7:0]             len_hi_ff, len_hi_in;
   kind_type               marker_ff, marker_in;
   logic [POS_WIDTH-1:0]   mstart_ff, mstart_in;

   logic [15:0]            seg_len;
   logic [END_WIDTH-1:0]   pos_next_ext;
   status_type             status;
   logic [POS_WIDTH-1:0]   scan;
   phase_type              after_seg;

   assign seg_len      = {len_hi_ff, data_byte};
   assign pos_next_ext = END_WIDTH'(pos_ff) + END_WIDTH'(1);
   assign after_seg    = (marker_ff == K_SOS) ? PH_SCAN : PH_PREFIX;

   always_comb begin
      phase_in   = phase_ff;
      seg_end_in = seg_end_ff;
      len_hi_in  = len_hi_ff;
      marker_in  = marker_ff;
      mstart_in  = mstart_ff;
      status     = ST_BUSY;
      scan       = '0;
      case (phase_ff)
         PH_PREFIX: begin
            if (data_byte != PREFIX_BYTE) begin
               status   = ST_NOT_MARKER;
               phase_in = PH_DONE;
            end else begin
               mstart_in = pos_ff;
               phase_in  = PH_ID;
            end
         end
         PH_ID: begin
            marker_in = classify(data_byte);
            phase_in  = (classify(data_byte) == K_SOI) ? PH_PREFIX : PH_LENHI;
         end
         PH_LENHI: begin
            len_hi_in = data_byte;
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            if (seg_len < 16'd2) begin
               status   = ST_BAD_LENGTH;
               phase_in = PH_DONE;
            end else begin
               seg_end_in = END_WIDTH'(mstart_ff) + END_WIDTH'(seg_len) + END_WIDTH'(2);
               phase_in   = (seg_len == 16'd2) ? after_seg : PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (pos_next_ext == seg_end_ff) phase_in = after_seg;
         end
         PH_SCAN: begin
            status   = ST_HEADER;
            scan     = pos_ff;
            phase_in = PH_DONE;
         end
         default: begin
            status   = ST_IGNORED;
            phase_in = PH_DONE;
         end
      endcase
      pos_in = pos_ff + POS_WIDTH'(1);
      if (last_byte && status == ST_BUSY) status = ST_TRUNCATED;
   end

   // outputs reflect the marker state after this byte, before any rearm
   always_comb begin
      result.status        = status;
      result.marker_kind   = marker_in;
      result.marker_offset = OUT_WIDTH'(mstart_in);
      result.scan_offset   = OUT_WIDTH'(scan);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_PREFIX;
         pos_ff     <= '0;
         seg_end_ff <= '0;
         len_hi_ff  <= '0;
         marker_ff  <= K_NONE;
         mstart_ff  <= '0;
      end else if (accept) begin
         if (last_byte) begin
            phase_ff   <= PH_PREFIX;
            pos_ff     <= '0;
            seg_end_ff <= '0;
            len_hi_ff  <= '0;
            marker_ff  <= K_NONE;
            mstart_ff  <= '0;
         end else begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            seg_end_ff <= seg_end_in;
            len_hi_ff  <= len_hi_in;
            marker_ff  <= marker_in;
            mstart_ff  <= mstart_in;
         end
      end
   end

endmodule

FILE: rtl/jmsw_obuf.sv
// result register with a skid stage so a byte can be taken while a word waits
// depends on jmsw_pkg
module jmsw_obuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jmsw_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_ready,
   output jmsw_pkg::result_type out_data
);
   import jmsw_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;
   logic       free;

   assign free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_in       = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

FILE: rtl/jmsw_checker.sv
// port-level checks for the jpeg marker segment walker, bound to the top level
// depends on jmsw_pkg, jpeg_marker_segment_walker
module jmsw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [5:0]  rsp_tuser
);
   import jmsw_pkg::*;

   // scan data is only found after a start-of-scan segment
   a_header_after_sos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ST_HEADER |-> rsp_tuser[5:3] == K_SOS)
      else $error("header done without start-of-scan marker");

   a_scan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] != ST_HEADER |-> rsp_tdata[47:24] == '0)
      else $error("scan offset set without header done");

   a_no_word_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind jpeg_marker_segment_walker jmsw_checker u_jmsw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
